[rtl/jacobi_stencil_sweep_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Jacobi stencil sweep block
// Shared property forms, all clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef JACOBI_STENCIL_SWEEP_ASSERT_SVH
`define JACOBI_STENCIL_SWEEP_ASSERT_SVH

// Same-cycle implication
`define JSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("jss: same-cycle check failed");

// Next-cycle implication
`define JSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("jss: next-cycle check failed");

`endif

[rtl/jss_pkg.sv]
// ----------------------------------------------------------------------------
// jss_pkg
// Types and constants of the Jacobi 5-point stencil sweep.
// ----------------------------------------------------------------------------
package jss_pkg;

    localparam int GRID_ROWS     = 512;
    localparam int GRID_COLS     = 512;
    localparam int FRACTION_BITS = 16;

    localparam int DATA_W  = 24;
    localparam int SUM_W   = DATA_W + 2;
    localparam int INDEX_W = 9;
    localparam int ROW_W   = $clog2(GRID_ROWS);
    localparam int COL_W   = $clog2(GRID_COLS);

    // round(0.001 * 2^FRACTION_BITS), kept to the sample width
    localparam longint unsigned TOL_FULL =
        ((64'd1 << FRACTION_BITS) + 64'd500) / 64'd1000;
    localparam logic [DATA_W-1:0] TOL_RESET = DATA_W'(TOL_FULL);

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [COL_W-1:0]  col_t;

    typedef struct packed {
        row_t row;
        col_t col;
    } pos_t;

    typedef struct packed {
        data_t              new_value;
        logic [INDEX_W-1:0] row_index;
        logic [INDEX_W-1:0] col_index;
        data_t              change;
        data_t              sweep_max_change;
        logic               last_of_sweep;
        logic               converged;
    } result_t;

    localparam row_t ROW_LAST = ROW_W'(GRID_ROWS - 1);
    localparam col_t COL_LAST = COL_W'(GRID_COLS - 1);

endpackage

[rtl/jss_line_store.sv]
// ----------------------------------------------------------------------------
// jss_line_store
// Two row buffers: the previous row and the row before it, one word per column.
// ----------------------------------------------------------------------------
module jss_line_store (
    input  logic          aclk,
    input  logic          rd_en,
    input  jss_pkg::col_t rd_addr,
    input  logic          wr_en,
    input  jss_pkg::col_t wr_addr,
    input  jss_pkg::data_t wr_prev,
    input  jss_pkg::data_t wr_older,
    output jss_pkg::data_t rd_prev,
    output jss_pkg::data_t rd_older
);
    import jss_pkg::*;

    data_t prev_mem  [GRID_COLS];
    data_t older_mem [GRID_COLS];
    data_t rd_prev_reg;
    data_t rd_older_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            prev_mem[wr_addr]  <= wr_prev;
            older_mem[wr_addr] <= wr_older;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_prev_reg  <= prev_mem[rd_addr];
            rd_older_reg <= older_mem[rd_addr];
        end
    end

    assign rd_prev  = rd_prev_reg;
    assign rd_older = rd_older_reg;

endmodule

[rtl/jss_stencil_core.sv]
// ----------------------------------------------------------------------------
// jss_stencil_core
// Neighbor window, 5-point update, change and running maximum.
// ----------------------------------------------------------------------------
module jss_stencil_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  jss_pkg::data_t   sample,
    input  jss_pkg::data_t   prev,
    input  jss_pkg::data_t   older,
    input  jss_pkg::pos_t    pos,
    input  jss_pkg::data_t   tolerance,
    output logic             has_result,
    output jss_pkg::result_t result
);
    import jss_pkg::*;

    // north, centre, west, south
    data_t north_reg, centre_reg, west_reg, south_reg;
    data_t max_reg, max_next;

    logic [SUM_W-1:0] sum;
    data_t            new_value;
    data_t            change;
    data_t            max_upd;
    logic             last;

    always_comb begin
        sum = {2'b00, north_reg} + {2'b00, south_reg}
            + {2'b00, west_reg} + {2'b00, prev};
        new_value  = sum[SUM_W-1:2];
        change     = (new_value >= centre_reg) ? (new_value - centre_reg)
                                               : (centre_reg - new_value);
        max_upd    = (change > max_reg) ? change : max_reg;
        has_result = (pos.row >= ROW_W'(2)) && (pos.col >= COL_W'(2));
        last       = (pos.row == ROW_LAST) && (pos.col == COL_LAST);

        result.new_value        = new_value;
        result.row_index        = INDEX_W'(pos.row - ROW_W'(1));
        result.col_index        = INDEX_W'(pos.col - COL_W'(1));
        result.change           = change;
        result.sweep_max_change = max_upd;
        result.last_of_sweep    = last;
        result.converged        = last && (max_upd < tolerance);

        // clear at the end of the grid so the next word starts a new sweep
        if (last) begin
            max_next = '0;
        end else if (has_result) begin
            max_next = max_upd;
        end else begin
            max_next = max_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            north_reg  <= '0;
            centre_reg <= '0;
            west_reg   <= '0;
            south_reg  <= '0;
            max_reg    <= '0;
        end else if (advance) begin
            west_reg   <= centre_reg;
            centre_reg <= prev;
            north_reg  <= older;
            south_reg  <= sample;
            max_reg    <= max_next;
        end
    end

endmodule

[rtl/jacobi_stencil_sweep.sv]
// ----------------------------------------------------------------------------
// jacobi_stencil_sweep
// One streaming Jacobi sweep of the 5-point Laplace stencil over the plate.
// ----------------------------------------------------------------------------
//  channel | ports                       | moves
//  --------+-----------------------------+-----------------------------------
//  input   | s_valid/s_ready, s_sample   | one grid word in raster order
//  result  | m_valid/m_ready, m_*        | one updated interior point
//  config  | cfg_we, cfg_wdata           | tolerance, no wait, no read-back
//
// One word per cycle sustained unless the result channel stalls. The line
// store read and the input stage are registered as a word is accepted; the
// stencil add, absolute change and maximum compare feed the result register.
// Border words in rows 0-1 and columns 0-1 produce no result.
// A stalled result register holds the stencil stage, which holds the input.
// Reset is synchronous; line store contents are not cleared.
// ----------------------------------------------------------------------------
module jacobi_stencil_sweep (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  jss_pkg::data_t                       cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  jss_pkg::data_t                       s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output jss_pkg::data_t                       m_new_value,
    output logic [jss_pkg::INDEX_W-1:0]          m_row_index,
    output logic [jss_pkg::INDEX_W-1:0]          m_col_index,
    output jss_pkg::data_t                       m_change,
    output jss_pkg::data_t                       m_sweep_max_change,
    output logic                                 m_last_of_sweep,
    output logic                                 m_converged
);
    import jss_pkg::*;

    data_t   tol_reg;
    row_t    row_reg, row_next;
    col_t    col_reg, col_next;
    logic    v1_reg;
    data_t   sample1_reg;
    pos_t    pos1_reg;
    logic    out_valid_reg;
    result_t out_reg;

    logic    s_accept;
    logic    adv1;
    logic    has_result;
    result_t result;
    data_t   prev;
    data_t   older;

    assign adv1     = v1_reg && (!has_result || !out_valid_reg || m_ready);
    assign s_ready  = !v1_reg || adv1;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        row_next = row_reg;
        col_next = col_reg + COL_W'(1);
        if (col_reg == COL_LAST) begin
            col_next = '0;
            row_next = (row_reg == ROW_LAST) ? '0 : row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_we) begin
            tol_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
            v1_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (s_accept) begin
                v1_reg <= 1'b1;
            end else if (adv1) begin
                v1_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample1_reg  <= s_sample;
            pos1_reg.row <= row_reg;
            pos1_reg.col <= col_reg;
        end
    end

    jss_line_store u_line_store (
        .aclk     (aclk),
        .rd_en    (s_accept),
        .rd_addr  (col_reg),
        .wr_en    (adv1),
        .wr_addr  (pos1_reg.col),
        .wr_prev  (sample1_reg),
        .wr_older (prev),
        .rd_prev  (prev),
        .rd_older (older)
    );

    jss_stencil_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (adv1),
        .sample     (sample1_reg),
        .prev       (prev),
        .older      (older),
        .pos        (pos1_reg),
        .tolerance  (tol_reg),
        .has_result (has_result),
        .result     (result)
    );

    // result register: load a new word, or drop the old one once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv1 && has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && has_result) begin
            out_reg <= result;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_new_value        = out_reg.new_value;
    assign m_row_index        = out_reg.row_index;
    assign m_col_index        = out_reg.col_index;
    assign m_change           = out_reg.change;
    assign m_sweep_max_change = out_reg.sweep_max_change;
    assign m_last_of_sweep    = out_reg.last_of_sweep;
    assign m_converged        = out_reg.converged;

`include "jacobi_stencil_sweep_assert.svh"

    `JSS_ASSERT_NOW(a_conv_only_last, m_valid && m_converged, m_last_of_sweep)
    `JSS_ASSERT_NOW(a_change_le_max, m_valid, m_change <= m_sweep_max_change)
    `JSS_ASSERT_NEXT(a_stage_hold, v1_reg && !adv1, v1_reg && $stable(pos1_reg))
    `JSS_ASSERT_NOW(a_no_overrun, adv1 && has_result && out_valid_reg, m_ready)

endmodule
